@@ hdl/smx_pkg.sv @@
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and constants of the stack machine executor: word and
// address widths, opcodes and fault codes.
// ----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

    localparam int WORD_BITS   = 32;
    localparam int STACK_DEPTH = 128;
    localparam int CODE_DEPTH  = 1024;
    localparam int SADDR_BITS  = $clog2(STACK_DEPTH);
    localparam int TOP_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int CADDR_BITS  = $clog2(CODE_DEPTH);

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [SADDR_BITS-1:0] saddr_t;
    typedef logic [TOP_BITS-1:0]   top_t;
    typedef logic [CADDR_BITS-1:0] caddr_t;
    typedef logic [4:0]            opcode_t;
    typedef logic [2:0]            fault_t;

    localparam opcode_t OP_LOAD   = 5'd0;
    localparam opcode_t OP_LOADI  = 5'd1;
    localparam opcode_t OP_STO    = 5'd2;
    localparam opcode_t OP_STI    = 5'd3;
    localparam opcode_t OP_ADD    = 5'd4;
    localparam opcode_t OP_SUB    = 5'd5;
    localparam opcode_t OP_MULT   = 5'd6;
    localparam opcode_t OP_DIV    = 5'd7;
    localparam opcode_t OP_MOD    = 5'd8;
    localparam opcode_t OP_BR     = 5'd9;
    localparam opcode_t OP_BRF    = 5'd10;
    localparam opcode_t OP_EQ     = 5'd11;
    localparam opcode_t OP_NOTEQ  = 5'd12;
    localparam opcode_t OP_GT     = 5'd13;
    localparam opcode_t OP_LES    = 5'd14;
    localparam opcode_t OP_GE     = 5'd15;
    localparam opcode_t OP_LE     = 5'd16;
    localparam opcode_t OP_AND    = 5'd17;
    localparam opcode_t OP_OR     = 5'd18;
    localparam opcode_t OP_NOT    = 5'd19;
    localparam opcode_t OP_IN     = 5'd20;
    localparam opcode_t OP_OUT    = 5'd21;
    localparam opcode_t OP_RETURN = 5'd22;
    localparam opcode_t OP_ENTER  = 5'd23;
    localparam opcode_t OP_CAL    = 5'd24;

    localparam fault_t FAULT_NONE      = 3'd0;
    localparam fault_t FAULT_OVERFLOW  = 3'd1;
    localparam fault_t FAULT_UNDERFLOW = 3'd2;
    localparam fault_t FAULT_DIVZERO   = 3'd3;
    localparam fault_t FAULT_FRAME     = 3'd4;

endpackage

`default_nettype wire

@@ hdl/smx_stack_mem.sv @@
// ----------------------------------------------------------------------------
// smx_stack_mem
// Stack word memory: one write port, two registered read ports. Per-entry
// valid bits make never-written words read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_stack_mem (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_en,
    input  wire smx_pkg::saddr_t wr_addr,
    input  wire smx_pkg::word_t  wr_data,
    input  wire smx_pkg::saddr_t rd_addr_a,
    input  wire smx_pkg::saddr_t rd_addr_b,
    output smx_pkg::word_t       rd_data_a,
    output smx_pkg::word_t       rd_data_b
);
    import smx_pkg::*;

    word_t                  mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] vld_reg;
    word_t                  rda_reg;
    word_t                  rdb_reg;
    logic                   vla_reg;
    logic                   vlb_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rda_reg <= mem[rd_addr_a];
        rdb_reg <= mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            vla_reg <= 1'b0;
            vlb_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            vla_reg <= vld_reg[rd_addr_a];
            vlb_reg <= vld_reg[rd_addr_b];
        end
    end

    assign rd_data_a = vla_reg ? rda_reg : '0;
    assign rd_data_b = vlb_reg ? rdb_reg : '0;

endmodule

`default_nettype wire

@@ hdl/smx_divider.sv @@
// ----------------------------------------------------------------------------
// smx_divider
// Radix-2 restoring divider on unsigned word magnitudes, one quotient bit
// per cycle. done pulses for one cycle when quotient and remainder are ready.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_divider (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire smx_pkg::word_t dividend,
    input  wire smx_pkg::word_t divisor,
    output logic               done,
    output smx_pkg::word_t      quotient,
    output smx_pkg::word_t      remainder
);
    import smx_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic [WORD_BITS:0]  rem_reg;
    word_t               quo_reg;
    word_t               dvs_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                done_reg;
    logic [WORD_BITS:0]  rem_shift;
    logic [WORD_BITS:0]  diff;

    assign rem_shift = {rem_reg[WORD_BITS-1:0], quo_reg[WORD_BITS-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            if (!diff[WORD_BITS]) begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_BITS'(WORD_BITS);
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_BITS'(1));
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[WORD_BITS-1:0];

endmodule

`default_nettype wire

@@ hdl/stack_machine_executor_core.sv @@
// ----------------------------------------------------------------------------
// stack_machine_executor_core
// Executes one stack-machine instruction per request on a 128-word stack.
//
// s_ channel: one instruction per request (opcode, operand, IN value).
// m_ channel: one result per request (next fetch address, OUT value, halt,
// fault code).
// Each request reads up to two stack words from the stack memory (registered
// read ports), then computes and writes back at most one word (CAL writes
// two). A request passes through READ and EXEC, then CAL2 for CAL or DIVW
// for DIV and MOD while the bit-serial divider runs, then RESP; no new request
// is accepted before it is back in IDLE. The result is registered leaving RESP.
// The result sits in an output register; when the receiver stalls, the
// block finishes the next instruction and holds it until the register is
// free. Reset clears top index, frame base and instruction pointer and
// marks every stack word as zero at once.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_executor_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire smx_pkg::opcode_t s_opcode,
    input  wire smx_pkg::word_t   s_operand,
    input  wire smx_pkg::word_t   s_input_value,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output smx_pkg::caddr_t       m_next_fetch,
    output logic                  m_out_valid,
    output smx_pkg::word_t        m_out_value,
    output logic                  m_halted,
    output smx_pkg::fault_t       m_fault
);
    import smx_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_EXEC = 6'b000100,
        ST_DIVW = 6'b001000,
        ST_CAL2 = 6'b010000,
        ST_RESP = 6'b100000
    } state_t;

    localparam int SUM_BITS = WORD_BITS + 2;

    state_t  state_reg, state_next;
    opcode_t op_reg;
    word_t   opnd_reg;
    word_t   inval_reg;
    top_t    top_reg, top_next;
    saddr_t  fb_reg, fb_next;
    caddr_t  ip_reg, ip_next;
    caddr_t  res_ip_reg, res_ip_next;
    logic    res_ov_reg, res_ov_next;
    word_t   res_val_reg, res_val_next;
    fault_t  res_flt_reg, res_flt_next;
    logic    m_valid_reg;
    caddr_t  m_nf_reg;
    logic    m_ov_reg;
    word_t   m_val_reg;
    fault_t  m_flt_reg;

    logic    wr_en;
    saddr_t  wr_addr;
    word_t   wr_data;
    saddr_t  rd_addr_a, rd_addr_b;
    word_t   rd_a, rd_b;

    logic    div_start, div_done;
    word_t   div_q, div_r;
    logic    neg_a, neg_b;
    word_t   mag_a, mag_b;
    word_t   div_res;

    logic signed [SUM_BITS-1:0] opnd_ext;
    logic signed [SUM_BITS-1:0] addr_sum;
    logic signed [SUM_BITS-1:0] enter_sum;
    logic    addr_ok;
    saddr_t  addr;
    caddr_t  ip_inc;
    caddr_t  jump_ip;
    word_t   alu_res;
    logic    is_binary;
    logic    s_acc, m_free;

    smx_stack_mem u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    smx_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // address and operand arithmetic
    assign opnd_ext  = SUM_BITS'($signed(opnd_reg));
    assign addr_sum  = $signed({{(SUM_BITS-SADDR_BITS){1'b0}}, fb_reg}) + opnd_ext;
    assign enter_sum = $signed({{(SUM_BITS-TOP_BITS){1'b0}}, top_reg}) + opnd_ext;
    assign addr_ok   = (addr_sum[SUM_BITS-1:SADDR_BITS] == '0);
    assign addr      = addr_sum[SADDR_BITS-1:0];
    assign ip_inc    = ip_reg + CADDR_BITS'(1);
    assign jump_ip   = opnd_reg[CADDR_BITS-1:0];
    assign is_binary = (op_reg inside {[OP_ADD:OP_MOD], [OP_EQ:OP_OR]});

    always_comb begin
        rd_addr_a = SADDR_BITS'(top_reg - TOP_BITS'(1));
        rd_addr_b = SADDR_BITS'(top_reg - TOP_BITS'(1));
        case (op_reg)
            OP_LOAD: begin
                rd_addr_a = addr;
            end
            OP_RETURN: begin
                rd_addr_a = fb_reg;
                rd_addr_b = fb_reg + SADDR_BITS'(1);
            end
            default: begin
                if (is_binary) begin
                    rd_addr_a = SADDR_BITS'(top_reg - TOP_BITS'(2));
                end
            end
        endcase
    end

    // signed division magnitudes and sign fix
    assign neg_a   = rd_a[WORD_BITS-1];
    assign neg_b   = rd_b[WORD_BITS-1];
    assign mag_a   = neg_a ? (~rd_a + WORD_BITS'(1)) : rd_a;
    assign mag_b   = neg_b ? (~rd_b + WORD_BITS'(1)) : rd_b;
    assign div_res = (op_reg == OP_MOD) ?
                     (neg_a ? (~div_r + WORD_BITS'(1)) : div_r) :
                     ((neg_a != neg_b) ? (~div_q + WORD_BITS'(1)) : div_q);

    always_comb begin
        case (op_reg)
            OP_ADD:   alu_res = rd_a + rd_b;
            OP_SUB:   alu_res = rd_a - rd_b;
            OP_MULT:  alu_res = WORD_BITS'(rd_a * rd_b);
            OP_EQ:    alu_res = WORD_BITS'(rd_a == rd_b);
            OP_NOTEQ: alu_res = WORD_BITS'(rd_a != rd_b);
            OP_GT:    alu_res = WORD_BITS'($signed(rd_a) > $signed(rd_b));
            OP_LES:   alu_res = WORD_BITS'($signed(rd_a) < $signed(rd_b));
            OP_GE:    alu_res = WORD_BITS'($signed(rd_a) >= $signed(rd_b));
            OP_LE:    alu_res = WORD_BITS'($signed(rd_a) <= $signed(rd_b));
            OP_AND:   alu_res = WORD_BITS'((rd_a != '0) && (rd_b != '0));
            OP_OR:    alu_res = WORD_BITS'((rd_a != '0) || (rd_b != '0));
            default:  alu_res = '0;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign m_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        top_next     = top_reg;
        fb_next      = fb_reg;
        ip_next      = ip_reg;
        res_ip_next  = res_ip_reg;
        res_ov_next  = res_ov_reg;
        res_val_next = res_val_reg;
        res_flt_next = res_flt_reg;
        wr_en        = 1'b0;
        wr_addr      = SADDR_BITS'(top_reg);
        wr_data      = '0;
        div_start    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                res_ip_next  = ip_inc;
                res_ov_next  = 1'b0;
                res_val_next = '0;
                res_flt_next = FAULT_NONE;
                state_next   = ST_RESP;
                case (op_reg)
                    OP_LOAD, OP_LOADI, OP_IN: begin
                        if (top_reg >= TOP_BITS'(STACK_DEPTH)) begin
                            res_flt_next = FAULT_OVERFLOW;
                        end else if (op_reg == OP_LOAD && !addr_ok) begin
                            res_flt_next = FAULT_FRAME;
                        end else begin
                            wr_en    = 1'b1;
                            wr_data  = (op_reg == OP_LOAD)  ? rd_a :
                                       (op_reg == OP_LOADI) ? opnd_reg : inval_reg;
                            top_next = top_reg + TOP_BITS'(1);
                        end
                    end
                    OP_STO: begin
                        if (top_reg == '0) begin
                            res_flt_next = FAULT_UNDERFLOW;
                        end else if (!addr_ok) begin
                            res_flt_next = FAULT_FRAME;
                        end else begin
                            wr_en    = 1'b1;
                            wr_addr  = addr;
                            wr_data  = rd_a;
                            top_next = top_reg - TOP_BITS'(1);
                        end
                    end
                    OP_BR: begin
                        res_ip_next = jump_ip;
                    end
                    OP_BRF: begin
                        if (top_reg == '0) begin
                            res_flt_next = FAULT_UNDERFLOW;
                        end else begin
                            top_next = top_reg - TOP_BITS'(1);
                            if (rd_a == '0) begin
                                res_ip_next = jump_ip;
                            end
                        end
                    end
                    OP_NOT: begin
                        if (top_reg == '0) begin
                            res_flt_next = FAULT_UNDERFLOW;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = rd_addr_a;
                            wr_data = WORD_BITS'(rd_a == '0);
                        end
                    end
                    OP_OUT: begin
                        if (top_reg == '0) begin
                            res_flt_next = FAULT_UNDERFLOW;
                        end else begin
                            res_ov_next  = 1'b1;
                            res_val_next = rd_a;
                            top_next     = top_reg - TOP_BITS'(1);
                        end
                    end
                    OP_RETURN: begin
                        if (fb_reg == SADDR_BITS'(STACK_DEPTH - 1)) begin
                            res_flt_next = FAULT_FRAME;
                        end else if ($signed(rd_a) < 0 ||
                                     $signed(rd_a) > $signed(WORD_BITS'(STACK_DEPTH - 2))) begin
                            res_flt_next = FAULT_FRAME;
                        end else begin
                            top_next    = TOP_BITS'(fb_reg);
                            fb_next     = rd_a[SADDR_BITS-1:0];
                            res_ip_next = rd_b[CADDR_BITS-1:0];
                        end
                    end
                    OP_ENTER: begin
                        if (enter_sum < 0) begin
                            res_flt_next = FAULT_UNDERFLOW;
                        end else if (enter_sum > $signed(SUM_BITS'(STACK_DEPTH))) begin
                            res_flt_next = FAULT_OVERFLOW;
                        end else begin
                            top_next = enter_sum[TOP_BITS-1:0];
                        end
                    end
                    OP_CAL: begin
                        if (top_reg >= TOP_BITS'(STACK_DEPTH - 1)) begin
                            res_flt_next = FAULT_OVERFLOW;
                        end else begin
                            wr_en       = 1'b1;
                            wr_data     = WORD_BITS'(fb_reg);
                            res_ip_next = jump_ip;
                            state_next  = ST_CAL2;
                        end
                    end
                    default: begin
                        if (is_binary) begin
                            if (top_reg < TOP_BITS'(2)) begin
                                res_flt_next = FAULT_UNDERFLOW;
                            end else if ((op_reg == OP_DIV || op_reg == OP_MOD) &&
                                         rd_b == '0) begin
                                res_flt_next = FAULT_DIVZERO;
                            end else if (op_reg == OP_DIV || op_reg == OP_MOD) begin
                                div_start  = 1'b1;
                                state_next = ST_DIVW;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = rd_addr_a;
                                wr_data  = alu_res;
                                top_next = top_reg - TOP_BITS'(1);
                            end
                        end
                    end
                endcase
            end
            ST_DIVW: begin
                if (div_done) begin
                    wr_en      = 1'b1;
                    wr_addr    = rd_addr_a;
                    wr_data    = div_res;
                    top_next   = top_reg - TOP_BITS'(1);
                    state_next = ST_RESP;
                end
            end
            ST_CAL2: begin
                // second frame word: return address, then new frame base
                wr_en      = 1'b1;
                wr_addr    = SADDR_BITS'(top_reg + TOP_BITS'(1));
                wr_data    = WORD_BITS'(ip_inc);
                fb_next    = SADDR_BITS'(top_reg);
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_free) begin
                    ip_next    = res_ip_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg    <= s_opcode;
            opnd_reg  <= s_operand;
            inval_reg <= s_input_value;
        end
        res_ip_reg  <= res_ip_next;
        res_ov_reg  <= res_ov_next;
        res_val_reg <= res_val_next;
        res_flt_reg <= res_flt_next;
        if (state_reg == ST_RESP && m_free) begin
            m_nf_reg  <= res_ip_reg;
            m_ov_reg  <= res_ov_reg;
            m_val_reg <= res_val_reg;
            m_flt_reg <= res_flt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            top_reg     <= '0;
            fb_reg      <= '0;
            ip_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            fb_reg    <= fb_next;
            ip_reg    <= ip_next;
            if (state_reg == ST_RESP && m_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_next_fetch = m_nf_reg;
    assign m_out_valid  = m_ov_reg;
    assign m_out_value  = m_val_reg;
    assign m_halted     = (m_nf_reg == '0);
    assign m_fault      = m_flt_reg;

endmodule

`default_nettype wire
